// ===== hw/rtl/bmgs_pkg.sv =====
// Package: constants and types shared by the Box-Muller Gaussian sampler.
package bmgs_pkg;

   localparam int LOG_ROUNDS = 32;
   localparam int HORNER_N   = 6;
   localparam int TRIG_CARRY = 2 * HORNER_N;
   localparam int TRIG_N     = 3 + 2 * HORNER_N;
   localparam int SAMPLE_N   = 3;
   localparam int LANES      = 2;
   localparam int LANE_COS   = 0;
   localparam int LANE_SIN   = 1;

   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [30:0] PI_Q29  = 31'd1686629713;

   localparam logic [13:0] OCTANT   = 14'h2000;
   localparam logic [14:0] QUADRANT = 15'h4000;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   localparam logic [31:0] MEAN_RESET      = 32'd0;
   localparam logic [23:0] DEVIATION_RESET = 24'd65536;

   localparam logic CSR_MEAN      = 1'b0;
   localparam logic CSR_DEVIATION = 1'b1;

   // Exact floor division of a 32-bit value: (q * ceil(2^k / d)) >> k, k = 32 + ceil(log2 d)
   localparam logic [33:0] SIN_RECIP [HORNER_N] = '{
      34'(((64'd1 << 40) + 64'd155) / 64'd156),
      34'(((64'd1 << 39) + 64'd109) / 64'd110),
      34'(((64'd1 << 39) + 64'd71) / 64'd72),
      34'(((64'd1 << 38) + 64'd41) / 64'd42),
      34'(((64'd1 << 37) + 64'd19) / 64'd20),
      34'(((64'd1 << 35) + 64'd5) / 64'd6)
   };
   localparam int SIN_SHIFT [HORNER_N] = '{40, 39, 39, 38, 37, 35};

   localparam logic [33:0] COS_RECIP [HORNER_N] = '{
      34'(((64'd1 << 40) + 64'd131) / 64'd132),
      34'(((64'd1 << 39) + 64'd89) / 64'd90),
      34'(((64'd1 << 38) + 64'd55) / 64'd56),
      34'(((64'd1 << 37) + 64'd29) / 64'd30),
      34'(((64'd1 << 36) + 64'd11) / 64'd12),
      34'(((64'd1 << 33) + 64'd1) / 64'd2)
   };
   localparam int COS_SHIFT [HORNER_N] = '{40, 39, 38, 37, 36, 33};

   typedef struct packed {
      logic [1:0]  quad;
      logic        swap;
      logic [13:0] g;
   } angle_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic        swap;
      logic [31:0] x;
      logic [31:0] x2;
   } trig_carry_type;

   typedef struct packed {
      logic [32:0] mag;
      logic        neg;
   } trig_type;

endpackage

// ===== hw/rtl/box_muller_gaussian_sampler.sv =====
// Box-Muller Gaussian sampler: fully pipelined fixed-point datapath.
//
// req channel: one transaction carries a Q0.32 radius fraction and a Q0.16
// angle fraction (valid/stall). rsp channel: one transaction per request with
// two Gaussian samples in signed Q16.16 and a saturation flag.
// csr port: index 0 writes the mean (signed Q16.16), index 1 the deviation
// (unsigned Q8.16); a zero deviation write is dropped. Write only while idle.
//
// Throughput: one transaction per cycle while rsp_stall does not hold a pending
// result. The depth comes from the 32 squaring stages of the log2 unit and the
// one-bit-per-stage square-root unit (square-root width 28 for the default
// UNIFORM_BITS); the trig branch (Horner series) runs alongside them.
// Reset clears the valid bits and loads mean 0, deviation 1.0.
// When rsp_stall holds a pending result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or duplicated.
module box_muller_gaussian_sampler
   import bmgs_pkg::*;
#(
   parameter int UNIFORM_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_uniform_radius,
   input  logic [15:0] req_uniform_angle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_cos,
   output logic [31:0] rsp_sample_sin,
   output logic        rsp_saturated,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int UW       = (UNIFORM_BITS < 32) ? UNIFORM_BITS : 32;
   localparam int P_W      = $clog2(UW);
   localparam int TI_W     = $clog2(UNIFORM_BITS + 1);
   localparam int T_W      = TI_W + 32;
   localparam int S_W      = T_W + 1;
   localparam int RAD_W    = ((S_W + 17) / 2) * 2;
   localparam int R_W      = RAD_W / 2;
   localparam int SQ_N     = R_W;
   localparam int REM_W    = R_W + 1;
   localparam int REMX_W   = R_W + 3;
   localparam int PM_W     = R_W + 1;
   localparam int A_W      = PM_W + 24;
   localparam int V_W      = A_W + 1 - 24;
   localparam int SUM_W    = (V_W + 2 > 33) ? V_W + 2 : 33;
   localparam int SQRT_END = LOG_ROUNDS + 2 + SQ_N;
   localparam int ANG_DLY  = SQRT_END - TRIG_N + 1;
   localparam int LAT      = SQRT_END + 1 + SAMPLE_N;

   logic            advance;
   logic [LAT-1:0]  vld_ff;
   logic [31:0]     mean_ff;
   logic [23:0]     deviation_ff;

   assign advance   = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT-1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff      <= MEAN_RESET;
         deviation_ff <= DEVIATION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MEAN: begin
               mean_ff <= csr_write_data;
            end
            CSR_DEVIATION: begin
               if (csr_write_data[23:0] != '0) begin
                  deviation_ff <= csr_write_data[23:0];
               end
            end
            default: begin
               mean_ff <= mean_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- input stage: normalize radius, fold angle ----------------
   logic [UW-1:0]    u_w;
   logic [P_W-1:0]   top_w;
   logic [UW+29:0]   norm_w;
   logic [13:0]      g_w;
   logic             swap_w;

   always_comb begin
      u_w = req_uniform_radius[UW-1:0];
      if (u_w == '0) begin
         u_w = {{(UW-1){1'b0}}, 1'b1};
      end
      top_w = '0;
      for (int i = 0; i < UW; i++) begin
         if (u_w[i]) begin
            top_w = P_W'(i);
         end
      end
      norm_w = {u_w, 30'd0} >> top_w;
      g_w    = req_uniform_angle[13:0];
      swap_w = 1'b0;
      if (g_w > OCTANT) begin
         g_w    = 14'(QUADRANT - {1'b0, g_w});
         swap_w = 1'b1;
      end
   end

   // ---------------- log2 fraction: one squaring per stage ----------------
   logic [30:0]      log_m_ff [LOG_ROUNDS+1];
   logic [31:0]      log_f_ff [LOG_ROUNDS+1];
   logic [P_W-1:0]   log_p_ff [LOG_ROUNDS+1];
   logic [30:0]      log_m_in [LOG_ROUNDS];
   logic [31:0]      log_f_in [LOG_ROUNDS];

   for (genvar i = 0; i < LOG_ROUNDS; i++) begin : g_log
      logic [61:0] sq_w;
      logic [31:0] hi_w;
      assign sq_w = 62'(log_m_ff[i]) * 62'(log_m_ff[i]);
      assign hi_w = sq_w[61:30];
      assign log_m_in[i] = hi_w[31] ? hi_w[31:1] : hi_w[30:0];
      assign log_f_in[i] = log_f_ff[i] | ({31'd0, hi_w[31]} << (LOG_ROUNDS - 1 - i));
   end

   // ---------------- -2 ln(u) and square root ----------------
   logic [T_W-1:0]   t_ff;
   logic [T_W-1:0]   t_in;
   logic [S_W-1:0]   s_w;
   logic [RAD_W-1:0] sqrt_rad_ff  [SQ_N+1];
   logic [REM_W-1:0] sqrt_rem_ff  [SQ_N+1];
   logic [R_W-1:0]   sqrt_root_ff [SQ_N+1];
   logic [RAD_W-1:0] sqrt_rad_in  [SQ_N];
   logic [REM_W-1:0] sqrt_rem_in  [SQ_N];
   logic [R_W-1:0]   sqrt_root_in [SQ_N];

   assign t_in = {TI_W'(UNIFORM_BITS - int'(log_p_ff[LOG_ROUNDS])), 32'd0}
               - T_W'(log_f_ff[LOG_ROUNDS]);
   assign s_w  = S_W'((64'(t_ff[T_W-1:8]) * 64'(LN2_Q32)) >> 23);

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      logic [REMX_W-1:0] remx_w;
      logic [REMX_W-1:0] trial_w;
      logic              ge_w;
      assign remx_w  = {sqrt_rem_ff[j], sqrt_rad_ff[j][RAD_W-1 -: 2]};
      assign trial_w = REMX_W'({sqrt_root_ff[j], 2'b01});
      assign ge_w    = remx_w >= trial_w;
      assign sqrt_rem_in[j]  = ge_w ? REM_W'(remx_w - trial_w) : REM_W'(remx_w);
      assign sqrt_root_in[j] = {sqrt_root_ff[j][R_W-2:0], ge_w};
      assign sqrt_rad_in[j]  = {sqrt_rad_ff[j][RAD_W-3:0], 2'b00};
   end

   // ---------------- angle: delay, then sine/cosine series ----------------
   angle_type        ang_dly_ff [ANG_DLY];
   logic [31:0]      tr_x_ff;
   logic [1:0]       tr_quad_ff;
   logic             tr_swap_ff;
   trig_carry_type   carry_ff  [TRIG_CARRY+1];
   logic [31:0]      qsin_ff   [HORNER_N];
   logic [31:0]      qcos_ff   [HORNER_N];
   logic [32:0]      hsin_ff   [1:HORNER_N];
   logic [32:0]      hcos_ff   [1:HORNER_N];
   logic [31:0]      qsin_in   [HORNER_N];
   logic [31:0]      qcos_in   [HORNER_N];
   logic [32:0]      hsin_in   [HORNER_N];
   logic [32:0]      hcos_in   [HORNER_N];

   for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
      logic [32:0] hs_cur_w;
      logic [32:0] hc_cur_w;
      if (k == 0) begin : g_first
         assign hs_cur_w = ONE_Q32;
         assign hc_cur_w = ONE_Q32;
      end else begin : g_next
         assign hs_cur_w = hsin_ff[k];
         assign hc_cur_w = hcos_ff[k];
      end
      assign qsin_in[k] = 32'((65'(carry_ff[2*k].x2) * 65'(hs_cur_w)) >> 32);
      assign qcos_in[k] = 32'((65'(carry_ff[2*k].x2) * 65'(hc_cur_w)) >> 32);
      assign hsin_in[k] = ONE_Q32
                        - 33'((66'(qsin_ff[k]) * 66'(SIN_RECIP[k])) >> SIN_SHIFT[k]);
      assign hcos_in[k] = ONE_Q32
                        - 33'((66'(qcos_ff[k]) * 66'(COS_RECIP[k])) >> COS_SHIFT[k]);
   end

   logic [32:0] s0_w;
   logic [32:0] base_c_w;
   logic [32:0] base_s_w;
   trig_type    trig_in [LANES];

   always_comb begin
      s0_w = 33'((65'(carry_ff[TRIG_CARRY].x) * 65'(hsin_ff[HORNER_N])) >> 32);
      if (carry_ff[TRIG_CARRY].swap) begin
         base_c_w = s0_w;
         base_s_w = hcos_ff[HORNER_N];
      end else begin
         base_c_w = hcos_ff[HORNER_N];
         base_s_w = s0_w;
      end
      unique case (carry_ff[TRIG_CARRY].quad)
         QUAD_FIRST: begin
            trig_in[LANE_COS] = '{mag: base_c_w, neg: 1'b0};
            trig_in[LANE_SIN] = '{mag: base_s_w, neg: 1'b0};
         end
         QUAD_SECOND: begin
            trig_in[LANE_COS] = '{mag: base_s_w, neg: 1'b1};
            trig_in[LANE_SIN] = '{mag: base_c_w, neg: 1'b0};
         end
         QUAD_THIRD: begin
            trig_in[LANE_COS] = '{mag: base_c_w, neg: 1'b1};
            trig_in[LANE_SIN] = '{mag: base_s_w, neg: 1'b1};
         end
         QUAD_FOURTH: begin
            trig_in[LANE_COS] = '{mag: base_s_w, neg: 1'b0};
            trig_in[LANE_SIN] = '{mag: base_c_w, neg: 1'b1};
         end
         default: begin
            trig_in[LANE_COS] = '{mag: base_c_w, neg: 1'b0};
            trig_in[LANE_SIN] = '{mag: base_s_w, neg: 1'b0};
         end
      endcase
   end

   // ---------------- sample lanes: scale, round, offset, clip ----------------
   trig_type         trig_ff [LANES];
   logic [PM_W-1:0]  pm_ff   [LANES];
   logic             pneg_ff [LANES];
   logic [A_W-1:0]   acc_ff  [LANES];
   logic             aneg_ff [LANES];
   logic [31:0]      out_ff  [LANES];
   logic [31:0]      out_in  [LANES];
   logic             sat_in  [LANES];
   logic             rsp_saturated_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [A_W:0]           rnd_w;
      logic [V_W-1:0]         v_w;
      logic [SUM_W-1:0]       mag_w;
      logic [SUM_W-1:0]       sum_w;
      assign rnd_w = (A_W+1)'(acc_ff[l]) + (A_W+1)'(1 << 23);
      assign v_w   = rnd_w[A_W:24];
      assign mag_w = aneg_ff[l] ? SUM_W'(0) - SUM_W'(v_w) : SUM_W'(v_w);
      assign sum_w = mag_w + {{(SUM_W-32){mean_ff[31]}}, mean_ff};
      always_comb begin
         // fits in 32 bits when the bits above the sign all match it
         if (sum_w[SUM_W-1:31] == '0 || sum_w[SUM_W-1:31] == '1) begin
            out_in[l] = sum_w[31:0];
            sat_in[l] = 1'b0;
         end else begin
            out_in[l] = sum_w[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_in[l] = 1'b1;
         end
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         log_m_ff[0]   <= norm_w[30:0];
         log_f_ff[0]   <= '0;
         log_p_ff[0]   <= top_w;
         ang_dly_ff[0] <= '{quad: req_uniform_angle[15:14], swap: swap_w, g: g_w};
         for (int i = 0; i < LOG_ROUNDS; i++) begin
            log_m_ff[i+1] <= log_m_in[i];
            log_f_ff[i+1] <= log_f_in[i];
            log_p_ff[i+1] <= log_p_ff[i];
         end
         t_ff            <= t_in;
         sqrt_rad_ff[0]  <= RAD_W'({s_w, 16'd0});
         sqrt_rem_ff[0]  <= '0;
         sqrt_root_ff[0] <= '0;
         for (int j = 0; j < SQ_N; j++) begin
            sqrt_rad_ff[j+1]  <= sqrt_rad_in[j];
            sqrt_rem_ff[j+1]  <= sqrt_rem_in[j];
            sqrt_root_ff[j+1] <= sqrt_root_in[j];
         end
         for (int k = 0; k < ANG_DLY - 1; k++) begin
            ang_dly_ff[k+1] <= ang_dly_ff[k];
         end
         tr_x_ff    <= 32'((46'(ang_dly_ff[ANG_DLY-1].g) * 46'(PI_Q29)) >> 12);
         tr_quad_ff <= ang_dly_ff[ANG_DLY-1].quad;
         tr_swap_ff <= ang_dly_ff[ANG_DLY-1].swap;
         carry_ff[0] <= '{quad: tr_quad_ff, swap: tr_swap_ff, x: tr_x_ff,
                          x2: 32'((64'(tr_x_ff) * 64'(tr_x_ff)) >> 32)};
         for (int c = 0; c < TRIG_CARRY; c++) begin
            carry_ff[c+1] <= carry_ff[c];
         end
         for (int k = 0; k < HORNER_N; k++) begin
            qsin_ff[k]   <= qsin_in[k];
            qcos_ff[k]   <= qcos_in[k];
            hsin_ff[k+1] <= hsin_in[k];
            hcos_ff[k+1] <= hcos_in[k];
         end
         for (int l = 0; l < LANES; l++) begin
            trig_ff[l] <= trig_in[l];
            pm_ff[l]   <= PM_W'((64'(sqrt_root_ff[SQ_N]) * 64'(trig_ff[l].mag)) >> 32);
            pneg_ff[l] <= trig_ff[l].neg;
            acc_ff[l]  <= A_W'(pm_ff[l]) * A_W'(deviation_ff);
            aneg_ff[l] <= pneg_ff[l];
            out_ff[l]  <= out_in[l];
         end
         rsp_saturated_ff <= sat_in[LANE_COS] || sat_in[LANE_SIN];
      end
   end

   assign rsp_sample_cos = out_ff[LANE_COS];
   assign rsp_sample_sin = out_ff[LANE_SIN];
   assign rsp_saturated  = rsp_saturated_ff;

   // ---------------- assertions ----------------
   a_dev_zero_ignored: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && csr_index == CSR_DEVIATION && csr_write_data[23:0] == '0
      |=> $stable(deviation_ff))
      else $error("zero deviation write changed the register");

   a_log_normalized: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LOG_ROUNDS] |-> log_m_ff[LOG_ROUNDS][30])
      else $error("log2 mantissa left [1,2)");

   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQRT_END] |-> sqrt_rem_ff[SQ_N] <= {sqrt_root_ff[SQ_N], 1'b0})
      else $error("square root remainder out of bound");

   a_trig_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQRT_END] |->
         trig_ff[LANE_COS].mag <= ONE_Q32 && trig_ff[LANE_SIN].mag <= ONE_Q32)
      else $error("sine or cosine magnitude above one");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved while the result was stalled");

endmodule

// ===== tb/bmgs_sample_checker.sv =====
// Checker: watches the sampler's channels, predicts each sample pair and compares it.
`timescale 1ns / 100ps
module bmgs_sample_checker
   import bmgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_uniform_radius,
   input  logic [15:0] req_uniform_angle,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_sample_cos,
   input  logic [31:0] rsp_sample_sin,
   input  logic        rsp_saturated,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   output int          failures,
   output int          outstanding,
   output int          sample_count,
   output int          clip_count
);

   typedef struct packed {
      logic [31:0] sample_cos;
      logic [31:0] sample_sin;
      logic        saturated;
   } sample_pair_type;

   localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;

   sample_pair_type pending_samples[$];
   logic [31:0] mean_q;
   logic [23:0] deviation_q;

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // radius r = sqrt(-2 ln u1) in Q.24
   function automatic logic [63:0] radius_of(input logic [31:0] raw);
      logic [63:0] u, m, f, t, s;
      int p;
      u = {32'd0, raw};
      f = 0;
      p = 0;
      if (u == 0) u = 1;
      for (int i = 0; i < 64; i++) if (u[i]) p = i;
      m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            f[i] = 1'b1;
         end
      end
      t = (64'(32 - p) << 32) - f;
      s = ((t >> 8) * 64'(LN2_Q32)) >> 23;
      return isqrt(s << 16);
   endfunction

   function automatic logic [63:0] series(input logic [63:0] x2, input logic is_sin);
      logic [63:0] h, d;
      h = UNIT_Q32;
      for (int i = 0; i < HORNER_N; i++) begin
         case (i)
            0: d = is_sin ? 156 : 132;
            1: d = is_sin ? 110 : 90;
            2: d = is_sin ? 72 : 56;
            3: d = is_sin ? 42 : 30;
            4: d = is_sin ? 20 : 12;
            default: d = is_sin ? 6 : 2;
         endcase
         h = UNIT_Q32 - ((x2 * h) >> 32) / d;
      end
      return h;
   endfunction

   function automatic logic [31:0] scale_sample(input logic [63:0] r, input longint trig,
                                                inout logic clip);
      logic [63:0] mag, a;
      longint v;
      mag = (trig < 0) ? 64'(-trig) : 64'(trig);
      a = ((r * mag) >> 32) * 64'(deviation_q);
      v = longint'((a + (64'd1 << 23)) >> 24);
      if (trig < 0) v = -v;
      v = v + longint'(signed'(mean_q));
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         clip = 1'b1;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         clip = 1'b1;
      end
      return v[31:0];
   endfunction

   function automatic sample_pair_type predict_pair(input logic [31:0] radius,
                                                    input logic [15:0] angle);
      sample_pair_type res;
      logic [63:0] r, g, x, x2, c0, s0, tmp;
      logic [1:0] quad;
      logic swap, clip;
      longint cv, sv;
      r = radius_of(radius);
      quad = angle[15:14];
      g = {50'd0, angle[13:0]};
      swap = 1'b0;
      clip = 1'b0;
      // fold the upper half of each quadrant onto the lower octant
      if (g > 64'(OCTANT)) begin
         g = 64'(QUADRANT) - g;
         swap = 1'b1;
      end
      x = (g * 64'(PI_Q29)) >> 12;
      x2 = (x * x) >> 32;
      s0 = (x * series(x2, 1'b1)) >> 32;
      c0 = series(x2, 1'b0);
      if (swap) begin
         tmp = c0;
         c0 = s0;
         s0 = tmp;
      end
      case (quad)
         QUAD_FIRST:  begin cv = longint'(c0);  sv = longint'(s0);  end
         QUAD_SECOND: begin cv = -longint'(s0); sv = longint'(c0);  end
         QUAD_THIRD:  begin cv = -longint'(c0); sv = -longint'(s0); end
         default:     begin cv = longint'(s0);  sv = -longint'(c0); end
      endcase
      res.sample_cos = scale_sample(r, cv, clip);
      res.sample_sin = scale_sample(r, sv, clip);
      res.saturated = clip;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      sample_count = 0;
      clip_count = 0;
   end

   assign outstanding = pending_samples.size();

   always @(posedge clock) begin
      sample_pair_type want;
      if (reset) begin
         mean_q <= MEAN_RESET;
         deviation_q <= DEVIATION_RESET;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_MEAN) mean_q <= csr_write_data;
            else if (csr_write_data[23:0] != 0) deviation_q <= csr_write_data[23:0];
         end
         if (req_valid && !req_stall)
            pending_samples.push_back(predict_pair(req_uniform_radius, req_uniform_angle));
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $display("[%0t] unexpected transaction on rsp", $time);
               failures++;
            end else begin
               want = pending_samples.pop_front();
               sample_count++;
               if (want.saturated) clip_count++;
               if (rsp_sample_cos !== want.sample_cos)
                  report_mismatch("sample_cos", rsp_sample_cos, want.sample_cos);
               if (rsp_sample_sin !== want.sample_sin)
                  report_mismatch("sample_sin", rsp_sample_sin, want.sample_sin);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.saturated));
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the Gaussian sampler.
`timescale 1ns / 100ps
module tb
   import bmgs_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_uniform_radius = '0;
   logic [15:0] req_uniform_angle = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_sample_cos;
   logic [31:0] rsp_sample_sin;
   logic        rsp_saturated;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_MEAN;
   logic [31:0] csr_write_data = '0;

   int failures, outstanding, sample_count, clip_count;
   int items_sent = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   logic quiet = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   box_muller_gaussian_sampler dut (.*);

   bmgs_sample_checker sample_check (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("box_muller_gaussian_sampler test failed");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(2, 0) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 15)
                                                   : $urandom_range(3, 0);
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(10, 0);
      end
   end

   function automatic int gap_length();
      if (quiet) return 0;
      if ($urandom_range(19, 0) == 0) return $urandom_range(30, 10);
      if ($urandom_range(1, 0) == 0) return 0;
      return $urandom_range(3, 1);
   endfunction

   // entered just after a rising edge; returns just after the accepting edge or after the gap that follows it
   task automatic send_pair(input logic [31:0] radius, input logic [15:0] angle);
      logic go;
      int gap;
      req_valid <= 1'b1;
      req_uniform_radius <= radius;
      req_uniform_angle <= angle;
      do begin
         @(negedge clock) go = !req_stall;
         @(posedge clock);
      end while (!go);
      items_sent++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic which, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] random_radius();
      // bias toward very small and very large fractions so the log extremes get exercised
      case ($urandom_range(3, 0))
         0: return $urandom() >> $urandom_range(31, 0);
         1: return ~($urandom() >> $urandom_range(31, 0));
         default: return $urandom();
      endcase
   endfunction

   task automatic random_burst(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) quiet = 1'($urandom_range(1, 0));
         if (i == count * 3 / 4) quiet = 1'b0;
         send_pair(random_radius(), 16'($urandom()));
      end
   endtask

   initial begin
      logic [15:0] angles [14];
      logic [31:0] radii [4];
      angles = '{16'h0000, 16'h1FFF, 16'h2000, 16'h2001, 16'h3FFF, 16'h4000, 16'h6000,
                 16'h8000, 16'hA000, 16'hC000, 16'hE001, 16'hFFFF, 16'h5555, 16'hAAAA};
      radii = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: radius extremes, zero radius, octant folds and quadrants
      for (int i = 0; i < 14; i++) send_pair(radii[i % 4], angles[i]);
      for (int i = 0; i < 4; i++) send_pair(radii[i], 16'h0000);
      drain();

      random_burst(380);
      // sender holds off until the pipeline is empty, then resumes
      drain();
      random_burst(60);
      drain();

      write_csr(CSR_MEAN, 32'h7FFF_FFFF);
      write_csr(CSR_DEVIATION, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send_pair(radii[i], angles[i]);
      random_burst(320);
      drain();

      write_csr(CSR_MEAN, 32'h8000_0000);
      write_csr(CSR_DEVIATION, 32'h0000_0001);
      random_burst(320);
      drain();

      // zero deviation must be ignored
      write_csr(CSR_DEVIATION, 32'h0000_0000);
      write_csr(CSR_MEAN, 32'h7F00_0000);
      random_burst(300);
      drain();

      for (int k = 0; k < 3; k++) begin
         write_csr(CSR_MEAN, $urandom());
         write_csr(CSR_DEVIATION, ($urandom_range(1, 0) == 0) ? $urandom()
                                                             : $urandom_range(262144, 1));
         random_burst(180);
         drain();
      end

      $display("sent %0d sample requests, checked %0d results, %0d saturated",
               items_sent, sample_count, clip_count);
      $display("covered mean/deviation extremes, zero-deviation write and backpressure");
      if (failures == 0 && outstanding == 0) begin
         $display("box_muller_gaussian_sampler test passed");
      end else begin
         $display("box_muller_gaussian_sampler test failed");
      end
      $finish;
   end

endmodule
